/* sv/priority_sorted_ready_queue_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the priority sorted ready queue
// Concurrent checks, sampled on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_SORTED_READY_QUEUE_MACROS_SVH
`define PRIORITY_SORTED_READY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define PSRQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/psrq_pkg.sv */
// ---------------------------------------------------------------------------
// psrq_pkg
// Sizes, codes, command and result types of the priority sorted ready queue.
// ---------------------------------------------------------------------------
package psrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PRIO_BITS   = 16;
  localparam int STATE_BITS  = 3;
  localparam int MODE_BITS   = 2;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_BITS = 1;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);

  localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_SET    = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_READY_CODE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_CODE  = 1'd1;

  localparam logic [STATE_BITS-1:0] READY_CODE_RESET = 3'd0;
  localparam logic [STATE_BITS-1:0] DEAD_CODE_RESET  = 3'd3;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_SET,
    OP_NOP
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_NO_MATCH = 2'd1,
    STATUS_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    op_t                   op;
    logic [ID_BITS-1:0]    id;
    logic [PRIO_BITS-1:0]  prio;
    logic [STATE_BITS-1:0] state;
  } cmd_t;

  typedef struct packed {
    status_t               status;
    logic [COUNT_BITS-1:0] occupancy;
    logic                  is_empty;
    logic [ID_BITS-1:0]    head_id;
    logic [PRIO_BITS-1:0]  head_priority;
    logic [STATE_BITS-1:0] head_state;
  } result_t;

endpackage

/* sv/psrq_front.sv */
// ---------------------------------------------------------------------------
// psrq_front
// Takes input beats and decodes the mode into a command for the back end.
// ---------------------------------------------------------------------------
module psrq_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [psrq_pkg::MODE_BITS-1:0]    mode,
  input  logic [psrq_pkg::ID_BITS-1:0]      proc_id,
  input  logic [psrq_pkg::PRIO_BITS-1:0]    priority_req,
  input  logic [psrq_pkg::STATE_BITS-1:0]   new_state,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output psrq_pkg::cmd_t                    cmd
);

  logic           held;
  psrq_pkg::cmd_t cmd_reg;
  psrq_pkg::cmd_t decoded;

  // The holding register frees up in the same cycle its command moves on.
  assign in_ready  = !held || cmd_ready;
  assign cmd_valid = held;
  assign cmd       = cmd_reg;

  always_comb begin
    decoded.id    = proc_id;
    decoded.prio  = priority_req;
    decoded.state = new_state;
    unique case (mode)
      psrq_pkg::MODE_INSERT: decoded.op = psrq_pkg::OP_INSERT;
      psrq_pkg::MODE_REMOVE: decoded.op = psrq_pkg::OP_REMOVE;
      psrq_pkg::MODE_SET:    decoded.op = psrq_pkg::OP_SET;
      default:               decoded.op = psrq_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (cmd_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_reg <= decoded;
    end
  end

endmodule

/* sv/psrq_cmd_fifo.sv */
// ---------------------------------------------------------------------------
// psrq_cmd_fifo
// Short command queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module psrq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  psrq_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output psrq_pkg::cmd_t rd_cmd
);

  psrq_pkg::cmd_t                        mem [psrq_pkg::CMDQ_DEPTH];
  logic [psrq_pkg::CMDQ_PTR_BITS-1:0]    wr_ptr;
  logic [psrq_pkg::CMDQ_PTR_BITS-1:0]    rd_ptr;
  logic [psrq_pkg::CMDQ_CNT_BITS-1:0]    fill;
  logic                                  push;
  logic                                  pop;

  assign wr_ready = fill != psrq_pkg::CMDQ_CNT_BITS'(psrq_pkg::CMDQ_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_cmd   = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers wrap naturally because the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

endmodule

/* sv/psrq_back.sv */
// ---------------------------------------------------------------------------
// psrq_back
// Shift-cell sorted store: runs one command per cycle while results are taken, and registers the result.
// ---------------------------------------------------------------------------
module psrq_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [psrq_pkg::STATE_BITS-1:0]   ready_code,
  input  logic [psrq_pkg::STATE_BITS-1:0]   dead_code,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  psrq_pkg::cmd_t                    cmd,
  output logic                              res_valid,
  input  logic                              res_ready,
  output psrq_pkg::result_t                 res
);

  localparam int D = psrq_pkg::QUEUE_DEPTH;

  logic [psrq_pkg::ID_BITS-1:0]    id_q    [D];
  logic [psrq_pkg::PRIO_BITS-1:0]  prio_q  [D];
  logic [psrq_pkg::STATE_BITS-1:0] state_q [D];
  logic [psrq_pkg::COUNT_BITS-1:0] count;

  logic [psrq_pkg::ID_BITS-1:0]    id_next    [D];
  logic [psrq_pkg::PRIO_BITS-1:0]  prio_next  [D];
  logic [psrq_pkg::STATE_BITS-1:0] state_next [D];
  logic [psrq_pkg::COUNT_BITS-1:0] count_next;

  // Neighbor taps: the cell below (toward the head) and the cell above.
  logic [psrq_pkg::ID_BITS-1:0]    dn_id    [D];
  logic [psrq_pkg::PRIO_BITS-1:0]  dn_prio  [D];
  logic [psrq_pkg::STATE_BITS-1:0] dn_state [D];
  logic                            dn_gt    [D];
  logic [psrq_pkg::ID_BITS-1:0]    up_id    [D];
  logic [psrq_pkg::PRIO_BITS-1:0]  up_prio  [D];
  logic [psrq_pkg::STATE_BITS-1:0] up_state [D];

  logic [D-1:0]      occupied;
  logic [D-1:0]      gt;
  logic [D-1:0]      match;
  logic [D-1:0]      hit;
  logic              full;
  logic              fire;
  psrq_pkg::status_t status_next;
  psrq_pkg::result_t res_reg;
  logic              res_held;

  assign full      = count == psrq_pkg::COUNT_BITS'(D);
  assign cmd_ready = !res_held || res_ready;
  assign fire      = cmd_valid && cmd_ready;
  assign res_valid = res_held;
  assign res       = res_reg;

  for (genvar k = 0; k < D; k++) begin : g_cell
    assign occupied[k] = psrq_pkg::COUNT_BITS'(k) < count;
    assign gt[k]       = occupied[k] && (prio_q[k] > cmd.prio);
    assign match[k]    = occupied[k] && ((id_q[k] == cmd.id) || (state_q[k] == dead_code));
    assign hit[k]      = occupied[k] && (id_q[k] == cmd.id);
    if (k == 0) begin : g_head
      assign dn_id[k]    = cmd.id;
      assign dn_prio[k]  = cmd.prio;
      assign dn_state[k] = ready_code;
      assign dn_gt[k]    = 1'b1;
    end else begin : g_body
      assign dn_id[k]    = id_q[k-1];
      assign dn_prio[k]  = prio_q[k-1];
      assign dn_state[k] = state_q[k-1];
      assign dn_gt[k]    = gt[k-1];
    end
    if (k == D - 1) begin : g_tail
      assign up_id[k]    = id_q[k];
      assign up_prio[k]  = prio_q[k];
      assign up_state[k] = state_q[k];
    end else begin : g_inner
      assign up_id[k]    = id_q[k+1];
      assign up_prio[k]  = prio_q[k+1];
      assign up_state[k] = state_q[k+1];
    end
  end

  always_comb begin
    logic [D-1:0] upto;
    logic [D-1:0] below;
    upto  = '0;
    below = '0;
    for (int k = 0; k < D; k++) begin
      id_next[k]    = id_q[k];
      prio_next[k]  = prio_q[k];
      state_next[k] = state_q[k];
    end
    count_next  = count;
    status_next = psrq_pkg::STATUS_DONE;
    unique case (cmd.op)
      psrq_pkg::OP_INSERT: begin
        if (full) begin
          status_next = psrq_pkg::STATUS_FULL;
        end else begin
          // Cells ahead of the new entry stay, the new entry lands at the
          // first cell not strictly higher, everything after moves back.
          for (int k = 0; k < D; k++) begin
            if (!gt[k]) begin
              if (dn_gt[k]) begin
                id_next[k]    = cmd.id;
                prio_next[k]  = cmd.prio;
                state_next[k] = ready_code;
              end else begin
                id_next[k]    = dn_id[k];
                prio_next[k]  = dn_prio[k];
                state_next[k] = dn_state[k];
              end
            end
          end
          count_next = count + 1'b1;
        end
      end
      psrq_pkg::OP_REMOVE: begin
        if (match == '0) begin
          status_next = psrq_pkg::STATUS_NO_MATCH;
        end else begin
          // From the first match on, every cell pulls from the one above.
          for (int k = 0; k < D; k++) begin
            upto = ((D'(1) << k) << 1) - D'(1);
            if ((match & upto) != '0) begin
              id_next[k]    = up_id[k];
              prio_next[k]  = up_prio[k];
              state_next[k] = up_state[k];
            end
          end
          count_next = count - 1'b1;
        end
      end
      psrq_pkg::OP_SET: begin
        if (hit == '0) begin
          status_next = psrq_pkg::STATUS_NO_MATCH;
        end else begin
          for (int k = 0; k < D; k++) begin
            below = (D'(1) << k) - D'(1);
            if (hit[k] && ((hit & below) == '0)) begin
              state_next[k] = cmd.state;
            end
          end
        end
      end
      default: begin
        status_next = psrq_pkg::STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      res_held <= 1'b0;
    end else begin
      if (fire) begin
        count    <= count_next;
        res_held <= 1'b1;
      end else if (res_ready) begin
        res_held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int k = 0; k < D; k++) begin
        id_q[k]    <= id_next[k];
        prio_q[k]  <= prio_next[k];
        state_q[k] <= state_next[k];
      end
      res_reg.status    <= status_next;
      res_reg.occupancy <= count_next;
      res_reg.is_empty  <= count_next == '0;
      if (count_next == '0) begin
        res_reg.head_id       <= '0;
        res_reg.head_priority <= '0;
        res_reg.head_state    <= '0;
      end else begin
        res_reg.head_id       <= id_next[0];
        res_reg.head_priority <= prio_next[0];
        res_reg.head_state    <= state_next[0];
      end
    end
  end

endmodule

/* sv/priority_sorted_ready_queue.sv */
// ---------------------------------------------------------------------------
// priority_sorted_ready_queue
// Bounded ready queue of process entries kept in descending priority order.
// ---------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one command per beat: mode
// selects insert, remove or set state, with proc_id, priority_req (unsigned
// Q2.14) and new_state as operands. Each command yields exactly one result
// beat on the output channel (out_valid/out_ready) with a status code, the
// occupancy after the command, an empty flag and the head entry.
// The configuration channel (cfg_valid/cfg_ready) writes ready_code (index
// 0) or dead_code (index 1); it is always ready and is meant to be used
// while no command is in flight.
// A command passes a decode register, a two-entry command queue and the
// shift-cell store before its result beat is raised. Each stage moves one
// command per cycle while the receiver takes results, which sets the
// sustained rate at one command per cycle.
// Reset empties the queue and restores the register defaults (ready code
// zero, dead code three). When the receiver stalls, the result is held in
// the output register and commands back up into the queue until in_ready
// falls.
// ---------------------------------------------------------------------------
`include "priority_sorted_ready_queue_macros.svh"

module priority_sorted_ready_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [psrq_pkg::MODE_BITS-1:0]      mode,
  input  logic [psrq_pkg::ID_BITS-1:0]        proc_id,
  input  logic [psrq_pkg::PRIO_BITS-1:0]      priority_req,
  input  logic [psrq_pkg::STATE_BITS-1:0]     new_state,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psrq_pkg::STATUS_BITS-1:0]    status,
  output logic [psrq_pkg::COUNT_BITS-1:0]     occupancy,
  output logic                                is_empty,
  output logic [psrq_pkg::ID_BITS-1:0]        head_id,
  output logic [psrq_pkg::PRIO_BITS-1:0]      head_priority,
  output logic [psrq_pkg::STATE_BITS-1:0]     head_state,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psrq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [psrq_pkg::STATE_BITS-1:0]     cfg_data
);

  logic [psrq_pkg::STATE_BITS-1:0] ready_code;
  logic [psrq_pkg::STATE_BITS-1:0] dead_code;

  logic              front_valid;
  logic              front_ready;
  psrq_pkg::cmd_t    front_cmd;
  logic              back_valid;
  logic              back_ready;
  psrq_pkg::cmd_t    back_cmd;
  psrq_pkg::result_t result;

  // Terms used by the checks at the end.
  logic              over_depth;
  logic              at_depth;
  logic              empty_view;
  logic              drop_seen;
  logic              stalled;

  // Configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_code <= psrq_pkg::READY_CODE_RESET;
      dead_code  <= psrq_pkg::DEAD_CODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psrq_pkg::REG_READY_CODE: ready_code <= cfg_data;
        psrq_pkg::REG_DEAD_CODE:  dead_code  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  psrq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .proc_id      (proc_id),
    .priority_req (priority_req),
    .new_state    (new_state),
    .cmd_valid    (front_valid),
    .cmd_ready    (front_ready),
    .cmd          (front_cmd)
  );

  psrq_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_cmd   (back_cmd)
  );

  psrq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .ready_code (ready_code),
    .dead_code  (dead_code),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .cmd        (back_cmd),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (result)
  );

  assign status        = result.status;
  assign occupancy     = result.occupancy;
  assign is_empty      = result.is_empty;
  assign head_id       = result.head_id;
  assign head_priority = result.head_priority;
  assign head_state    = result.head_state;

  assign over_depth = occupancy > psrq_pkg::COUNT_BITS'(psrq_pkg::QUEUE_DEPTH);
  assign at_depth   = occupancy == psrq_pkg::COUNT_BITS'(psrq_pkg::QUEUE_DEPTH);
  assign empty_view = occupancy == '0 && head_id == '0 && head_priority == '0 &&
                      head_state == '0;
  assign drop_seen  = out_valid && status == psrq_pkg::STATUS_FULL;
  assign stalled    = out_valid && !out_ready;

  // The reported occupancy never exceeds the store size.
  `PSRQ_ASSERT_SAME(a_occ_bound, out_valid, !over_depth, "occupancy above queue depth")
  // An empty queue reports a zero head entry and zero occupancy.
  `PSRQ_ASSERT_SAME(a_empty_head, out_valid && is_empty, empty_view, "empty queue with head")
  // A dropped insert is only reported when the store is full.
  `PSRQ_ASSERT_SAME(a_full_drop, drop_seen, at_depth, "full status without full queue")
  // A result left waiting keeps its occupancy until it is taken.
  `PSRQ_ASSERT_NEXT(a_hold_result, stalled, out_valid && $stable(occupancy), "stalled result")

endmodule
